>>> design/efgw_pkg.sv
// Shared types and constants for the event flag group with waiter slots.
`default_nettype none

package efgw_pkg;

  localparam int WAITER_SLOTS_DEF = 8;
  localparam int WOKEN_W = 8;
  localparam logic [31:0] RESERVED_RESET = 32'h0200_0000;

  localparam int MODE_ANY_BIT = 0;
  localparam int MODE_ALL_BIT = 1;
  localparam int MODE_CLR_BIT = 2;

  typedef enum logic [1:0] {
    FN_WRITE   = 2'd0,
    FN_READ    = 2'd1,
    FN_CLEAR   = 2'd2,
    FN_TIMEOUT = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_MASK_ZERO = 3'd1,
    STAT_RESERVED  = 3'd2,
    STAT_BAD_MODE  = 3'd3,
    STAT_WAITING   = 3'd4,
    STAT_TIMEOUT   = 3'd5,
    STAT_SLOT      = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic in_stall;
    logic exec;
    logic scan;
    logic out_valid;
  } ctrl_t;

  typedef struct packed {
    logic go_scan;
    logic scan_last;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> design/efgw_match.sv
// Shared waiter compare unit: one slot's condition against the new events and flags.
`default_nettype none

module efgw_match (
  input  wire logic [31:0] w_mask,
  input  wire logic [2:0]  w_mode,
  input  wire logic [31:0] events,
  input  wire logic [31:0] flags,
  output logic             hit
);

  logic any_hit;
  logic all_hit;

  assign any_hit = w_mode[efgw_pkg::MODE_ANY_BIT] && ((w_mask & events) != 32'd0);
  assign all_hit = w_mode[efgw_pkg::MODE_ALL_BIT] && ((w_mask & flags) == w_mask);
  assign hit     = any_hit || all_hit;

endmodule

`default_nettype wire

>>> design/efgw_waiters.sv
// Waiter slot table: pending bits in flops, mask and mode in a small memory.
`default_nettype none

module efgw_waiters #(
  parameter int WAITER_SLOTS = efgw_pkg::WAITER_SLOTS_DEF,
  localparam int SLOT_W = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    wr_en,
  input  wire logic [SLOT_W-1:0]       wr_idx,
  input  wire logic [31:0]             wr_mask,
  input  wire logic [2:0]              wr_mode,
  input  wire logic                    clr_en,
  input  wire logic [SLOT_W-1:0]       clr_idx,
  input  wire logic [SLOT_W-1:0]       rd_idx,
  output logic [31:0]                  rd_mask,
  output logic [2:0]                   rd_mode,
  output logic [WAITER_SLOTS-1:0]      pend
);

  logic [31:0]             mask_mem [WAITER_SLOTS];
  logic [2:0]              mode_mem [WAITER_SLOTS];
  logic [31:0]             rd_mask_r;
  logic [2:0]              rd_mode_r;
  logic [WAITER_SLOTS-1:0] pend_r;
  logic [WAITER_SLOTS-1:0] pend_nxt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mask_mem[wr_idx] <= wr_mask;
      mode_mem[wr_idx] <= wr_mode;
    end
    rd_mask_r <= mask_mem[rd_idx];
    rd_mode_r <= mode_mem[rd_idx];
  end

  always_comb begin
    pend_nxt = pend_r;
    if (wr_en) begin
      pend_nxt[wr_idx] = 1'b1;
    end
    if (clr_en) begin
      pend_nxt[clr_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  assign rd_mask = rd_mask_r;
  assign rd_mode = rd_mode_r;
  assign pend    = pend_r;

endmodule

`default_nettype wire

>>> design/efgw_ctrl.sv
// Sequencer: accept, execute, slot scan and result hold.
`default_nettype none

module efgw_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                out_stall,
  input  wire efgw_pkg::dp_stat_t  dp_stat,
  output efgw_pkg::ctrl_t          ctrl
);

  efgw_pkg::state_t state_r;
  efgw_pkg::state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      efgw_pkg::S_IDLE: begin
        if (in_valid) state_nxt = efgw_pkg::S_EXEC;
      end
      efgw_pkg::S_EXEC: begin
        state_nxt = dp_stat.go_scan ? efgw_pkg::S_SCAN : efgw_pkg::S_OUT;
      end
      efgw_pkg::S_SCAN: begin
        if (dp_stat.scan_last) state_nxt = efgw_pkg::S_OUT;
      end
      efgw_pkg::S_OUT: begin
        if (!out_stall) state_nxt = efgw_pkg::S_IDLE;
      end
      default: state_nxt = efgw_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state_r)
      efgw_pkg::S_IDLE: begin
        ctrl.accept = in_valid;
      end
      efgw_pkg::S_EXEC: begin
        ctrl.in_stall = 1'b1;
        ctrl.exec     = 1'b1;
      end
      efgw_pkg::S_SCAN: begin
        ctrl.in_stall = 1'b1;
        ctrl.scan     = 1'b1;
      end
      efgw_pkg::S_OUT: begin
        ctrl.in_stall  = 1'b1;
        ctrl.out_valid = 1'b1;
      end
      default: ctrl.in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= efgw_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/event_flag_group_waiters_unit.sv
// Event flag group: 32-bit flag word with a table of parked waiters.
// Sequence: the input beat is registered, executed in S_EXEC and held in S_OUT;
//   a write that passes the reserved check also scans in S_SCAN, one waiter slot per cycle
//   through the shared compare unit.
// One item in flight: a new beat is taken only after the result has been accepted.
// Reset clears flags, pending bits and sequencer; reserved mask to 0x02000000.
`default_nettype none

module event_flag_group_waiters_unit #(
  parameter int WAITER_SLOTS = efgw_pkg::WAITER_SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_func,
  input  wire logic [31:0] in_mask_value,
  input  wire logic [2:0]  in_mode,
  input  wire logic        in_wait_enable,
  input  wire logic [2:0]  in_waiter_slot,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [31:0]      out_matched_flags,
  output logic [7:0]       out_woken_slots
);

  localparam int SLOT_W = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;

  efgw_pkg::ctrl_t    ctrl;
  efgw_pkg::dp_stat_t dp_stat;

  // item registers
  efgw_pkg::func_t func_r;
  logic [31:0]     mask_r;
  logic [2:0]      mode_r;
  logic            wait_r;
  logic [2:0]      slot_r;

  logic [31:0]       reserved_r;
  logic [31:0]       flags_r;
  logic [31:0]       flags_nxt;
  logic [SLOT_W-1:0] scan_idx_r;
  logic [SLOT_W-1:0] scan_idx_nxt;
  efgw_pkg::status_t status_r;
  efgw_pkg::status_t status_nxt;
  logic [31:0]       matched_r;
  logic [31:0]       matched_nxt;
  logic [7:0]        woken_r;
  logic [7:0]        woken_nxt;

  logic                    wr_en;
  logic                    clr_en;
  logic [SLOT_W-1:0]       clr_idx;
  logic [31:0]             w_mask;
  logic [2:0]              w_mode;
  logic [WAITER_SLOTS-1:0] pend;
  logic                    match_hit;

  logic [31:0]       slot_ext;
  logic [SLOT_W-1:0] slot_idx;
  logic              slot_ok;
  logic              slot_pend;
  logic [31:0]       scan_ext;
  logic [31:0]       rd_and;
  logic [31:0]       rd_hit;
  logic              mode_bad;

  assign slot_ext  = 32'(slot_r);
  assign slot_idx  = slot_ext[SLOT_W-1:0];
  assign slot_ok   = slot_ext < 32'(WAITER_SLOTS);
  assign slot_pend = slot_ok && pend[slot_idx];
  assign scan_ext  = 32'(scan_idx_r);

  assign rd_and   = flags_r & mask_r;
  assign mode_bad = mode_r[efgw_pkg::MODE_ANY_BIT] == mode_r[efgw_pkg::MODE_ALL_BIT];
  assign rd_hit   = mode_r[efgw_pkg::MODE_ANY_BIT] ? rd_and :
                    ((rd_and == mask_r) ? mask_r : 32'd0);

  efgw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .dp_stat   (dp_stat),
    .ctrl      (ctrl)
  );

  efgw_waiters #(
    .WAITER_SLOTS (WAITER_SLOTS)
  ) u_waiters (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_idx  (slot_idx),
    .wr_mask (mask_r),
    .wr_mode (mode_r),
    .clr_en  (clr_en),
    .clr_idx (clr_idx),
    .rd_idx  (scan_idx_nxt),
    .rd_mask (w_mask),
    .rd_mode (w_mode),
    .pend    (pend)
  );

  // scan uses the written event bits for any-mode and the updated flags for all-mode
  efgw_match u_match (
    .w_mask (w_mask),
    .w_mode (w_mode),
    .events (mask_r),
    .flags  (flags_r),
    .hit    (match_hit)
  );

  always_comb begin
    dp_stat.scan_last = scan_ext == 32'(WAITER_SLOTS - 1);
    flags_nxt         = flags_r;
    status_nxt        = status_r;
    matched_nxt       = matched_r;
    woken_nxt         = woken_r;
    scan_idx_nxt      = scan_idx_r;
    wr_en             = 1'b0;
    clr_en            = 1'b0;
    clr_idx           = scan_idx_r;
    dp_stat.go_scan   = 1'b0;

    if (ctrl.exec) begin
      status_nxt   = efgw_pkg::STAT_OK;
      matched_nxt  = 32'd0;
      woken_nxt    = 8'd0;
      scan_idx_nxt = '0;
      case (func_r)
        efgw_pkg::FN_WRITE: begin
          if ((mask_r & reserved_r) != 32'd0) begin
            status_nxt = efgw_pkg::STAT_RESERVED;
          end else begin
            flags_nxt       = flags_r | mask_r;
            dp_stat.go_scan = 1'b1;
          end
        end
        efgw_pkg::FN_READ: begin
          if (mask_r == 32'd0) begin
            status_nxt = efgw_pkg::STAT_MASK_ZERO;
          end else if ((mask_r & reserved_r) != 32'd0) begin
            status_nxt = efgw_pkg::STAT_RESERVED;
          end else if (mode_bad) begin
            status_nxt = efgw_pkg::STAT_BAD_MODE;
          end else if (rd_hit != 32'd0) begin
            if (mode_r[efgw_pkg::MODE_CLR_BIT]) flags_nxt = flags_r & ~rd_hit;
            matched_nxt = rd_hit;
          end else if (wait_r) begin
            if (!slot_ok || slot_pend) begin
              status_nxt = efgw_pkg::STAT_SLOT;
            end else begin
              wr_en      = 1'b1;
              status_nxt = efgw_pkg::STAT_WAITING;
            end
          end
        end
        efgw_pkg::FN_CLEAR: begin
          flags_nxt = flags_r & mask_r;
        end
        efgw_pkg::FN_TIMEOUT: begin
          if (slot_pend) begin
            clr_en     = 1'b1;
            clr_idx    = slot_idx;
            status_nxt = efgw_pkg::STAT_TIMEOUT;
          end else begin
            status_nxt = efgw_pkg::STAT_SLOT;
          end
        end
        default: status_nxt = efgw_pkg::STAT_OK;
      endcase
    end

    if (ctrl.scan) begin
      if (!dp_stat.scan_last) scan_idx_nxt = scan_idx_r + SLOT_W'(1);
      if (pend[scan_idx_r] && match_hit) begin
        clr_en = 1'b1;
        if (scan_ext < 32'(efgw_pkg::WOKEN_W)) begin
          woken_nxt = woken_r | (8'd1 << scan_ext[2:0]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      func_r <= efgw_pkg::func_t'(in_func);
      mask_r <= in_mask_value;
      mode_r <= in_mode;
      wait_r <= in_wait_enable;
      slot_r <= in_waiter_slot;
    end
    status_r  <= status_nxt;
    matched_r <= matched_nxt;
    woken_r   <= woken_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reserved_r <= efgw_pkg::RESERVED_RESET;
      flags_r    <= 32'd0;
      scan_idx_r <= '0;
    end else begin
      if (cfg_wr_en) reserved_r <= cfg_wr_data;
      flags_r    <= flags_nxt;
      scan_idx_r <= scan_idx_nxt;
    end
  end

  assign in_stall          = ctrl.in_stall;
  assign out_valid         = ctrl.out_valid;
  assign out_status        = status_r;
  assign out_matched_flags = matched_r;
  assign out_woken_slots   = woken_r;

endmodule

`default_nettype wire

>>> design/efgw_chk.sv
// Port-level checker for the event flag group, bound to the top level.
`default_nettype none

module efgw_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  out_status,
  input wire logic [31:0] out_matched_flags,
  input wire logic [7:0]  out_woken_slots
);

  // one item in flight: no new beat while a result waits
  a_busy_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while result pending");

  a_no_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !out_valid)
    else $error("result shown in cycle after input beat");

  a_err_no_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != efgw_pkg::STAT_OK) |-> out_matched_flags == 32'd0)
    else $error("flags returned with error status");

  a_woken_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_woken_slots != 8'd0) |->
      (out_status == efgw_pkg::STAT_OK && out_matched_flags == 32'd0))
    else $error("woken slots on a non-write result");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status)))
    else $error("stalled result changed");

endmodule

bind event_flag_group_waiters_unit efgw_chk u_efgw_chk (.*);

`default_nettype wire
